// ===== hdl/swrx_crc8_pkg.sv =====
// Shared constants and CRC-8 step functions for the stop-and-wait receiver.
// No dependencies; imported by the receiver top level and the testbench.
package swrx_crc8_pkg;

   // Generator low byte after reset (x^8 + x^2 + x + 1)
   localparam logic [7:0] PolyReset    = 8'h07;
   // A frame needs one sequence bit plus eight CRC bits
   localparam logic [3:0] MinFrameBits = 4'd9;

   // One long-division step: shift the bit in below the remainder
   function automatic logic [7:0] divide_step(input logic [7:0] rem,
                                              input logic       bit_in,
                                              input logic [7:0] poly);
      logic [7:0] shifted;
      shifted = {rem[6:0], bit_in};
      return rem[7] ? (shifted ^ poly) : shifted;
   endfunction

   // One step of the augmented CRC (message times x^8 modulo the generator)
   function automatic logic [7:0] append_step(input logic [7:0] rem,
                                              input logic       bit_in,
                                              input logic [7:0] poly);
      logic [7:0] shifted;
      shifted = {rem[6:0], 1'b0};
      return (rem[7] ^ bit_in) ? (shifted ^ poly) : shifted;
   endfunction

endpackage

// ===== hdl/stop_and_wait_receiver_crc8.sv =====
// Stop-and-wait ARQ receiver: serial CRC-8 frame check and ACK/NACK reply.
// Depends on swrx_crc8_pkg for the CRC step functions and constants.
// The reply is registered and appears in the cycle after the beat carrying last_bit.
// Throughput: one bit beat per cycle while req_stall is low; the CRC step is one shift and XOR.
// Input stalls only while a reply sits in the output register and is stalled.
// Reset (synchronous, active high) clears frame state, expected sequence,
// the reply valid flag and loads the polynomial register with 0x07.
module stop_and_wait_receiver_crc8
   import swrx_crc8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   // received bit beats
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_data_bit,
   input  logic       req_last_bit,
   // reply beats
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_ack,
   output logic       rsp_reply_seq,
   output logic [7:0] rsp_reply_crc,
   output logic       rsp_crc_ok
);

   logic [7:0] crc_poly_ff,     crc_poly_in;
   logic [7:0] crc_rem_ff,      crc_rem_in;
   logic [8:0] recent_ff,       recent_in;
   logic [3:0] bits_seen_ff,    bits_seen_in;
   logic       expected_seq_ff, expected_seq_in;
   logic       rsp_valid_ff,    rsp_valid_in;
   logic       is_ack_ff,       is_ack_in;
   logic       reply_seq_ff,    reply_seq_in;
   logic [7:0] reply_crc_ff,    reply_crc_in;
   logic       crc_ok_ff,       crc_ok_in;

   logic       accept;
   logic       frame_end;
   logic [7:0] rem_step;
   logic [8:0] recent_step;
   logic [3:0] seen_step;
   logic       frame_ok;
   logic       take_ack;
   logic [7:0] crc_first;

   // Input stalls only when the held reply cannot leave this cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign frame_end = accept & req_last_bit;

   // Division and history update for the incoming bit
   always_comb begin
      rem_step    = divide_step(crc_rem_ff, req_data_bit, crc_poly_ff);
      recent_step = {recent_ff[7:0], req_data_bit};
      seen_step   = (bits_seen_ff < MinFrameBits) ? (bits_seen_ff + 4'd1) : bits_seen_ff;
      frame_ok    = (rem_step == 8'd0) && (seen_step >= MinFrameBits);
      take_ack    = frame_ok && (recent_step[8] == expected_seq_ff);
      crc_first   = append_step(8'd0, take_ack, crc_poly_ff);
   end

   // Next frame state and polynomial register; frame state cleared after the last bit
   always_comb begin
      crc_poly_in     = csr_wr_en ? csr_wr_data : crc_poly_ff;
      crc_rem_in      = crc_rem_ff;
      recent_in       = recent_ff;
      bits_seen_in    = bits_seen_ff;
      expected_seq_in = expected_seq_ff;
      if (accept) begin
         if (req_last_bit) begin
            crc_rem_in      = 8'd0;
            recent_in       = 9'd0;
            bits_seen_in    = 4'd0;
            expected_seq_in = expected_seq_ff ^ take_ack;
         end else begin
            crc_rem_in   = rem_step;
            recent_in    = recent_step;
            bits_seen_in = seen_step;
         end
      end
   end

   // Reply register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      is_ack_in    = is_ack_ff;
      reply_seq_in = reply_seq_ff;
      reply_crc_in = reply_crc_ff;
      crc_ok_in    = crc_ok_ff;
      if (frame_end) begin
         rsp_valid_in = 1'b1;
         is_ack_in    = take_ack;
         reply_seq_in = expected_seq_ff;
         reply_crc_in = append_step(crc_first, expected_seq_ff, crc_poly_ff);
         crc_ok_in    = frame_ok;
      end
   end

   // Control and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff     <= PolyReset;
         crc_rem_ff      <= 8'd0;
         recent_ff       <= 9'd0;
         bits_seen_ff    <= 4'd0;
         expected_seq_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         crc_poly_ff     <= crc_poly_in;
         crc_rem_ff      <= crc_rem_in;
         recent_ff       <= recent_in;
         bits_seen_ff    <= bits_seen_in;
         expected_seq_ff <= expected_seq_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Reply payload
   always_ff @(posedge clock) begin
      is_ack_ff    <= is_ack_in;
      reply_seq_ff <= reply_seq_in;
      reply_crc_ff <= reply_crc_in;
      crc_ok_ff    <= crc_ok_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_ack    = is_ack_ff;
   assign rsp_reply_seq = reply_seq_ff;
   assign rsp_reply_crc = reply_crc_ff;
   assign rsp_crc_ok    = crc_ok_ff;

endmodule

// ===== hdl/swrx_crc8_checker.sv =====
// Port-level checker for the stop-and-wait receiver, bound to the top level.
// Depends only on the top level's ports.
module swrx_crc8_checker (
   input logic       clock,
   input logic       reset,
   input logic       csr_wr_en,
   input logic [7:0] csr_wr_data,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_data_bit,
   input logic       req_last_bit,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_ack,
   input logic       rsp_reply_seq,
   input logic [7:0] rsp_reply_crc,
   input logic       rsp_crc_ok
);

   // A stalled reply beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_ack)
         && $stable(rsp_reply_seq) && $stable(rsp_reply_crc) && $stable(rsp_crc_ok))
      else $error("stalled reply beat changed");

   // Every accepted last bit yields a reply on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_bit |=> rsp_valid)
      else $error("frame end without reply");

   // A new reply only follows an accepted last bit
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_bit))
      else $error("reply without frame end");

   // ACK only for a frame that passed the CRC
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_ack |-> rsp_crc_ok)
      else $error("ACK on failed frame");

   // Message of two zero bits has a zero CRC
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_ack && !rsp_reply_seq |-> rsp_reply_crc == 8'd0)
      else $error("nonzero CRC for all-zero reply");

endmodule

bind stop_and_wait_receiver_crc8 swrx_crc8_checker u_swrx_crc8_checker (.*);

// ===== tb/tb_top.sv =====
// Testbench for stop_and_wait_receiver_crc8: bit beats in, ACK/NACK replies out.
// Needs the RTL and swrx_crc8_pkg only; predicts every reply and checks it in order.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import swrx_crc8_pkg::PolyReset;
   import swrx_crc8_pkg::MinFrameBits;

   localparam int QuietLimit   = 4000; // cycles with no beat before giving up
   localparam int ReplyLatency = 4;    // settle cycles before a register write

   typedef struct packed {
      logic       is_ack;
      logic       reply_seq;
      logic [7:0] reply_crc;
      logic       crc_ok;
   } reply_type;

   logic       clock;
   logic       reset         = 1'b1;
   logic       csr_wr_en     = 1'b0;
   logic [7:0] csr_wr_data   = 8'h00;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic       req_data_bit  = 1'b0;
   logic       req_last_bit  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic       rsp_is_ack;
   logic       rsp_reply_seq;
   logic [7:0] rsp_reply_crc;
   logic       rsp_crc_ok;

   stop_and_wait_receiver_crc8 uut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_bit  (req_data_bit),
      .req_last_bit  (req_last_bit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_ack    (rsp_is_ack),
      .rsp_reply_seq (rsp_reply_seq),
      .rsp_reply_crc (rsp_reply_crc),
      .rsp_crc_ok    (rsp_crc_ok)
   );

   // Receiver mirror state
   logic [7:0] rx_poly       = PolyReset;
   logic [7:0] rx_rem        = 8'h00;
   logic [8:0] rx_hist       = 9'h000;
   logic [3:0] rx_count      = 4'd0;
   logic       rx_expect_seq = 1'b0;

   reply_type pending_replies[$];
   int     err_cnt     = 0;
   int     bits_sent   = 0;
   bit     tx_steady   = 1'b0; // sender runs with no gaps
   bit     rx_steady   = 1'b0; // reply side never stalls

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // CRC of msg[n-1:0] (MSB first) times x^8 modulo the generator
   function automatic logic [7:0] crc_appended(input logic [63:0] msg, input int n,
                                               input logic [7:0] poly);
      logic [7:0] r;
      logic       fb;
      r = 8'h00;
      for (int i = n - 1; i >= 0; i--) begin
         fb = r[7] ^ msg[i];
         r  = {r[6:0], 1'b0};
         if (fb) r = r ^ poly;
      end
      return r;
   endfunction

   // Advance the mirror by one accepted bit; queue the reply on a last bit
   function automatic void absorb_bit(input logic d, input logic l);
      reply_type r;
      logic   good;
      rx_rem  = {rx_rem[6:0], d} ^ (rx_rem[7] ? rx_poly : 8'h00);
      rx_hist = {rx_hist[7:0], d};
      if (rx_count < MinFrameBits) rx_count = rx_count + 4'd1;
      if (l) begin
         good        = (rx_rem == 8'h00) && (rx_count >= MinFrameBits);
         r.crc_ok    = good;
         r.reply_seq = rx_expect_seq;
         r.is_ack    = good && (rx_hist[8] == rx_expect_seq);
         if (r.is_ack) rx_expect_seq = ~rx_expect_seq;
         r.reply_crc = crc_appended({62'd0, r.is_ack, r.reply_seq}, 2, rx_poly);
         pending_replies.push_back(r);
         rx_rem   = 8'h00;
         rx_hist  = 9'h000;
         rx_count = 4'd0;
      end
   endfunction

   // Send one bit beat after a random gap (none while tx_steady); returns at the accepting edge
   task automatic send_bit(input logic d, input logic l);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_data_bit <= d;
      req_last_bit <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_bit(d, l);
      bits_sent++;
   endtask

   // Frame held in frm[len-1:0], first bit on the line is frm[len-1]
   task automatic send_frame(input logic [63:0] frm, input int len);
      for (int i = len - 1; i >= 0; i--) send_bit(frm[i], i == 0);
   endtask

   // Well-formed frame: payload, sequence bit, then the eight CRC bits
   function automatic logic [63:0] build_frame(input logic [63:0] payload, input int plen,
                                               input logic seq);
      logic [63:0] msg;
      msg = ((payload & ((64'd1 << plen) - 64'd1)) << 1) | {63'd0, seq};
      return (msg << 8) | {56'd0, crc_appended(msg, plen + 1, rx_poly)};
   endfunction

   // Stop sending until every queued reply has been seen
   task automatic hold_until_replies_done();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic write_poly(input logic [7:0] poly);
      hold_until_replies_done();
      repeat (ReplyLatency) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= poly;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rx_poly = poly;
   endtask

   // Duplicate detection and frames too short to hold a sequence bit and CRC, reset polynomial
   task automatic test_short_and_duplicate_frames();
      logic [63:0] frm;
      frm = build_frame(64'd0, 0, 1'b0);
      send_frame(frm, 9);           // accepted, expected bit toggles
      send_frame(frm, 9);           // same sequence again: duplicate
      send_frame(64'd1, 1);         // one-bit frame
      send_frame(64'd0, 8);         // zero remainder but one bit short
   endtask

   // Mixed random traffic under one polynomial
   task automatic test_random_frames(input logic [7:0] poly, input int count);
      logic [63:0] frm;
      int          stop_at;
      int          kind;
      int          len;
      int          plen;
      logic        seq;
      write_poly(poly);
      stop_at = bits_sent + count;
      while (bits_sent < stop_at) begin
         if ($urandom_range(0, 7) == 0) tx_steady = ~tx_steady;
         if ($urandom_range(0, 7) == 0) rx_steady = ~rx_steady;
         kind = $urandom_range(0, 99);
         frm  = {$urandom, $urandom};
         if (kind < 65) begin
            // good frame, sometimes stale sequence or a flipped bit
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12);
            seq  = ($urandom_range(0, 4) == 0) ? ~rx_expect_seq : rx_expect_seq;
            frm  = build_frame(frm, plen, seq);
            len  = plen + 9;
            if ($urandom_range(0, 5) == 0) frm[$urandom_range(0, len - 1)] ^= 1'b1;
         end else if (kind < 80) begin
            len = $urandom_range(1, 8);
         end else begin
            len = $urandom_range(9, 24);
         end
         send_frame(frm, len);
         if ($urandom_range(0, 29) == 0) hold_until_replies_done();
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         err_cnt++;
      end
   endfunction

   // Reply side: random stall per beat, in-order comparison
   initial begin
      int        stall_left;
      reply_type exp_r;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid) begin
            if (!rsp_stall) begin
               if (pending_replies.size() == 0) begin
                  $display("%0t: unexpected reply beat, expected none, got ack=%0b seq=%0b",
                           $time, rsp_is_ack, rsp_reply_seq);
                  err_cnt++;
               end else begin
                  exp_r = pending_replies.pop_front();
                  check_field("is_ack", 8'(exp_r.is_ack), 8'(rsp_is_ack));
                  check_field("reply_seq", 8'(exp_r.reply_seq), 8'(rsp_reply_seq));
                  check_field("reply_crc", exp_r.reply_crc, rsp_reply_crc);
                  check_field("crc_ok", 8'(exp_r.crc_ok), 8'(rsp_crc_ok));
               end
               stall_left = rx_steady ? 0 : $urandom_range(0, 8);
            end else if (stall_left > 0) begin
               stall_left--;
            end
            rsp_stall <= (stall_left != 0);
         end
      end
   end

   // Watchdog: too long without any beat on either side
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= QuietLimit) begin
            $display("%0t: timeout, %0d replies still awaited", $time,
                     pending_replies.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_short_and_duplicate_frames();
      test_random_frames(8'h00, 220);
      test_random_frames(8'hFF, 220);
      test_random_frames(PolyReset, 220);
      test_random_frames(8'h31, 220);
      test_random_frames(8'($urandom_range(0, 255)), 220);
      test_random_frames(8'($urandom_range(0, 255)), 220);
      hold_until_replies_done();
      repeat (8) @(posedge clock);
      if (err_cnt == 0 && pending_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
